// ===== rtl/rdsm_pkg.sv =====
package rdsm_pkg;

    localparam int SAMPLE_W_DEF = 16;
    localparam int COEF_W_DEF   = 32;

    localparam int PHASE_W   = 32;
    localparam int SIG_W     = 40;
    localparam int SIG_FRAC  = 30;
    localparam int SPLIT     = 20;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [PHASE_W-1:0] STEP_RESET = 32'd26563943;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd32768;

    // +1.0 on the Q10.30 filter scale
    localparam logic signed [SIG_W-1:0] LEVEL_ONE = SIG_W'(64'sd1 <<< SIG_FRAC);

    localparam int NUM_STEPS = 16;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOL_STEP,
        REG_LPF_B0,
        REG_LPF_B1,
        REG_LPF_B2,
        REG_LPF_A1,
        REG_LPF_A2,
        REG_AMP_GAIN
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ASEL_X,
        ASEL_Y,
        ASEL_T
    } a_sel_t;

    typedef enum logic [2:0] {
        BSEL_B0,
        BSEL_B1,
        BSEL_B2,
        BSEL_A1,
        BSEL_A2,
        BSEL_CAR,
        BSEL_GAIN
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_COEF,
        SH_SIG,
        SH_GAIN
    } shift_sel_t;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_D0,
        BASE_D1,
        BASE_ACC
    } base_sel_t;

    typedef enum logic [2:0] {
        DEST_NONE,
        DEST_Y,
        DEST_D0,
        DEST_D1,
        DEST_T,
        DEST_O
    } dest_t;

    typedef struct packed {
        logic       active;
        logic       sec;
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        shift_sel_t shift_sel;
        base_sel_t  base_sel;
        logic       sub;
        dest_t      dest;
    } op_t;

    typedef struct packed {
        logic accept;
        logic issue;
        op_t  op;
        logic push;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH1,
        ST_FLUSH2,
        ST_PUSH
    } state_t;

    function automatic op_t mk_op(input logic sec, input a_sel_t a, input b_sel_t b,
                                  input shift_sel_t sh, input base_sel_t base,
                                  input logic sub, input dest_t dest);
        op_t op;
        op.active    = 1'b1;
        op.sec       = sec;
        op.a_sel     = a;
        op.b_sel     = b;
        op.shift_sel = sh;
        op.base_sel  = base;
        op.sub       = sub;
        op.dest      = dest;
        return op;
    endfunction

    // Issue schedule: both biquad sections, then carrier and gain products.
    // Empty slots wait out the three-stage pipeline where a later op reads an
    // earlier result.
    function automatic op_t seq_op(input logic [STEP_W-1:0] step);
        op_t op;
        op = '0;
        case (step)
            0:  op = mk_op(1'b0, ASEL_X, BSEL_B0, SH_COEF, BASE_D0,   1'b0, DEST_Y);
            1:  op = mk_op(1'b0, ASEL_X, BSEL_B1, SH_COEF, BASE_D1,   1'b0, DEST_NONE);
            3:  op = mk_op(1'b0, ASEL_Y, BSEL_A1, SH_COEF, BASE_ACC,  1'b1, DEST_D0);
            4:  op = mk_op(1'b0, ASEL_X, BSEL_B2, SH_COEF, BASE_ZERO, 1'b0, DEST_NONE);
            5:  op = mk_op(1'b0, ASEL_Y, BSEL_A2, SH_COEF, BASE_ACC,  1'b1, DEST_D1);
            6:  op = mk_op(1'b1, ASEL_X, BSEL_B0, SH_COEF, BASE_D0,   1'b0, DEST_Y);
            7:  op = mk_op(1'b1, ASEL_X, BSEL_B1, SH_COEF, BASE_D1,   1'b0, DEST_NONE);
            9:  op = mk_op(1'b1, ASEL_Y, BSEL_A1, SH_COEF, BASE_ACC,  1'b1, DEST_D0);
            10: op = mk_op(1'b1, ASEL_X, BSEL_B2, SH_COEF, BASE_ZERO, 1'b0, DEST_NONE);
            11: op = mk_op(1'b1, ASEL_Y, BSEL_A2, SH_COEF, BASE_ACC,  1'b1, DEST_D1);
            12: op = mk_op(1'b1, ASEL_Y, BSEL_CAR, SH_SIG, BASE_ZERO, 1'b0, DEST_T);
            15: op = mk_op(1'b0, ASEL_T, BSEL_GAIN, SH_GAIN, BASE_ZERO, 1'b0, DEST_O);
            default: op = '0;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/rds_biphase_subcarrier_modulator.sv =====
// RDS differential bi-phase modulator: one output item per input item (one DAC
// tick). From acceptance to a result in the output register an item passes the
// accept state, 16 issue slots into the shared pair of 21-bit by MB_W-bit
// multipliers (MB_W is the wider of coefficient and sample width plus one; ten
// biquad products, the carrier product, the gain product and four empty slots
// that wait out the three-stage multiply/merge/accumulate pipeline), FLUSH1 and
// FLUSH2, which drain it, and PUSH, which loads the output register. The next
// item can be accepted in the cycle after PUSH, while the previous result may
// still wait on m_tready; with a stalled output the block holds in PUSH until
// the register frees up. s_tdata carries the carrier sample and the offered
// bit, s_tuser says whether the offered bit is valid (otherwise idle bit 1 is
// sent). Configuration writes are taken at any time but belong between items.
module rds_biphase_subcarrier_modulator #(
    parameter int SAMPLE_W = rdsm_pkg::SAMPLE_W_DEF,
    parameter int COEF_W   = rdsm_pkg::COEF_W_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // carrier_sample, offered_bit
    input  logic [((SAMPLE_W + 1 + 7) / 8) * 8-1:0] s_tdata,
    // bit_ready
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_sample
    output logic [((SAMPLE_W + 7) / 8) * 8-1:0]    m_tdata,
    // bit_taken
    output logic                                   m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rdsm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((COEF_W > rdsm_pkg::PHASE_W) ? COEF_W : rdsm_pkg::PHASE_W)-1:0] cfg_data
);
    import rdsm_pkg::*;

    localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] out_sample;

    assign cfg_ready = 1'b1;

    rdsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    rdsm_dp #(
        .SAMPLE_W (SAMPLE_W),
        .COEF_W   (COEF_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .carrier_sample (s_tdata[SAMPLE_W-1:0]),
        .offered_bit    (s_tdata[SAMPLE_W]),
        .bit_ready      (s_tuser),
        .out_sample     (out_sample),
        .bit_taken      (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'(unsigned'(out_sample));

endmodule

// ===== rtl/rdsm_ctrl.sv =====
module rdsm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    output rdsm_pkg::cmd_t cmd
);
    import rdsm_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.op    = seq_op(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FLUSH1;
                end
            end
            ST_FLUSH1:
            begin
                state_next = ST_FLUSH2;
            end
            ST_FLUSH2:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/rdsm_dp.sv =====
module rdsm_dp #(
    parameter int SAMPLE_W = rdsm_pkg::SAMPLE_W_DEF,
    parameter int COEF_W   = rdsm_pkg::COEF_W_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rdsm_pkg::cmd_t                        cmd,
    input  logic                                  cfg_valid,
    input  logic [rdsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [((COEF_W > rdsm_pkg::PHASE_W) ? COEF_W : rdsm_pkg::PHASE_W)-1:0] cfg_data,
    input  logic signed [SAMPLE_W-1:0]            carrier_sample,
    input  logic                                  offered_bit,
    input  logic                                  bit_ready,
    output logic signed [SAMPLE_W-1:0]            out_sample,
    output logic                                  bit_taken
);
    import rdsm_pkg::*;

    localparam int COEF_FRAC = COEF_W - 2;
    localparam int MB_W      = ((COEF_W > SAMPLE_W) ? COEF_W : SAMPLE_W) + 1;
    localparam int MA_W      = SPLIT + 1;
    localparam int PW        = MA_W + MB_W;
    localparam int FW        = SIG_W + MB_W;
    localparam int ACC_W     = SIG_W + 4;

    // configuration
    logic [PHASE_W-1:0]       step_cfg_reg;
    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [GAIN_W-1:0]        gain_reg;

    // symbol state
    logic [PHASE_W-1:0] phase_reg;
    logic               diff_reg, half_reg;
    logic [PHASE_W:0]   phase_sum;
    logic               sym_bit;

    // item payload
    logic signed [SAMPLE_W-1:0] carrier_reg;
    logic                       level_neg_reg;
    logic                       taken_reg;

    // filter state and results
    logic signed [SIG_W-1:0] s0_d0_reg, s0_d1_reg, s1_d0_reg, s1_d1_reg;
    logic signed [SIG_W-1:0] y1_reg, y2_reg, t_reg;
    logic signed [SAMPLE_W-1:0] o_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // pipeline
    logic signed [SIG_W-1:0] a_op;
    logic signed [MB_W-1:0]  b_op;
    logic signed [MA_W-1:0]  a_lo, a_hi;
    logic signed [PW-1:0]    plo_reg, phi_reg;
    logic signed [FW-1:0]    full_reg, full_next, full_shr;
    op_t                     op2_reg, op3_reg;
    logic                    s2_valid_reg, s3_valid_reg;
    logic signed [ACC_W-1:0] prod, base, acc_next;
    logic signed [SIG_W-1:0] sig_sat;
    logic signed [SAMPLE_W-1:0] out_sat;
    logic                    sig_ovf, out_ovf;

    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       bit_taken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= STEP_RESET;
            b0_reg       <= '0;
            b1_reg       <= '0;
            b2_reg       <= '0;
            a1_reg       <= '0;
            a2_reg       <= '0;
            gain_reg     <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SYMBOL_STEP: step_cfg_reg <= cfg_data[PHASE_W-1:0];
                REG_LPF_B0:      b0_reg       <= cfg_data[COEF_W-1:0];
                REG_LPF_B1:      b1_reg       <= cfg_data[COEF_W-1:0];
                REG_LPF_B2:      b2_reg       <= cfg_data[COEF_W-1:0];
                REG_LPF_A1:      a1_reg       <= cfg_data[COEF_W-1:0];
                REG_LPF_A2:      a2_reg       <= cfg_data[COEF_W-1:0];
                REG_AMP_GAIN:    gain_reg     <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_cfg_reg};
    assign sym_bit   = bit_ready ? offered_bit : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            diff_reg  <= 1'b0;
            half_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            phase_reg <= phase_sum[PHASE_W-1:0];
            if (phase_sum[PHASE_W])
            begin
                half_reg <= 1'b0;
                diff_reg <= diff_reg ^ sym_bit;
            end
            else if (phase_sum[PHASE_W-1])
            begin
                half_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            carrier_reg   <= carrier_sample;
            level_neg_reg <= diff_reg ^ half_reg;
            taken_reg     <= phase_sum[PHASE_W];
        end
    end

    // stage 1: operand select and two partial products
    always_comb
    begin
        case (cmd.op.a_sel)
            ASEL_X:  a_op = cmd.op.sec ? y1_reg : (level_neg_reg ? -LEVEL_ONE : LEVEL_ONE);
            ASEL_Y:  a_op = cmd.op.sec ? y2_reg : y1_reg;
            ASEL_T:  a_op = t_reg;
            default: a_op = '0;
        endcase
        case (cmd.op.b_sel)
            BSEL_B0:   b_op = MB_W'(b0_reg);
            BSEL_B1:   b_op = MB_W'(b1_reg);
            BSEL_B2:   b_op = MB_W'(b2_reg);
            BSEL_A1:   b_op = MB_W'(a1_reg);
            BSEL_A2:   b_op = MB_W'(a2_reg);
            BSEL_CAR:  b_op = MB_W'(carrier_reg);
            BSEL_GAIN: b_op = MB_W'(gain_reg);
            default:   b_op = '0;
        endcase
        a_lo = {1'b0, a_op[SPLIT-1:0]};
        a_hi = MA_W'($signed(a_op[SIG_W-1:SPLIT]));
    end

    always_ff @(posedge clk)
    begin
        plo_reg  <= a_lo * b_op;
        phi_reg  <= a_hi * b_op;
        op2_reg  <= cmd.op;
        full_reg <= full_next;
        op3_reg  <= op2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= cmd.issue && cmd.op.active;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 2: merge partial products into the full product
    assign full_next = (FW'(phi_reg) <<< SPLIT) + FW'(plo_reg);

    // stage 3: scale, accumulate, saturate
    always_comb
    begin
        case (op3_reg.shift_sel)
            SH_COEF: full_shr = full_reg >>> COEF_FRAC;
            SH_SIG:  full_shr = full_reg >>> SIG_FRAC;
            SH_GAIN: full_shr = full_reg >>> GAIN_FRAC;
            default: full_shr = full_reg;
        endcase
        prod = full_shr[ACC_W-1:0];
        case (op3_reg.base_sel)
            BASE_ZERO: base = '0;
            BASE_D0:   base = ACC_W'(op3_reg.sec ? s1_d0_reg : s0_d0_reg);
            BASE_D1:   base = ACC_W'(op3_reg.sec ? s1_d1_reg : s0_d1_reg);
            BASE_ACC:  base = acc_reg;
            default:   base = '0;
        endcase
        acc_next = op3_reg.sub ? (base - prod) : (base + prod);

        sig_ovf = (acc_next[ACC_W-1:SIG_W-1] != {(ACC_W-SIG_W+1){acc_next[ACC_W-1]}});
        if (sig_ovf)
        begin
            sig_sat = acc_next[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}}
                                        : {1'b0, {(SIG_W-1){1'b1}}};
        end
        else
        begin
            sig_sat = acc_next[SIG_W-1:0];
        end

        out_ovf = (acc_next[ACC_W-1:SAMPLE_W-1]
                   != {(ACC_W-SAMPLE_W+1){acc_next[ACC_W-1]}});
        if (out_ovf)
        begin
            out_sat = acc_next[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            out_sat = acc_next[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_d0_reg <= '0;
            s0_d1_reg <= '0;
            s1_d0_reg <= '0;
            s1_d1_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            if (op3_reg.dest == DEST_D0)
            begin
                if (op3_reg.sec)
                begin
                    s1_d0_reg <= sig_sat;
                end
                else
                begin
                    s0_d0_reg <= sig_sat;
                end
            end
            if (op3_reg.dest == DEST_D1)
            begin
                if (op3_reg.sec)
                begin
                    s1_d1_reg <= sig_sat;
                end
                else
                begin
                    s0_d1_reg <= sig_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            acc_reg <= acc_next;
            case (op3_reg.dest)
                DEST_Y:
                begin
                    if (op3_reg.sec)
                    begin
                        y2_reg <= sig_sat;
                    end
                    else
                    begin
                        y1_reg <= sig_sat;
                    end
                end
                DEST_T:  t_reg <= acc_next[SIG_W-1:0];
                DEST_O:  o_reg <= out_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_sample_reg <= o_reg;
            bit_taken_reg  <= taken_reg;
        end
    end

    assign out_sample = out_sample_reg;
    assign bit_taken  = bit_taken_reg;

endmodule

// ===== rtl/rdsm_checker.sv =====
module rdsm_checker #(
    parameter int SAMPLE_W = rdsm_pkg::SAMPLE_W_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((SAMPLE_W + 7) / 8) * 8-1:0] m_tdata,
    input logic                                m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time: the block is busy, with s_tready low, after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input accepted while previous item in work");

    // a new result shows up only at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

endmodule

bind rds_biphase_subcarrier_modulator rdsm_checker #(
    .SAMPLE_W (SAMPLE_W)
) u_rdsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
